FILE: rtl/core/ifd_pkg.sv
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types, constants and field tables for the INS frame deframer.
// ----------------------------------------------------------------------------
package ifd_pkg;

    // Frame layout.
    localparam int unsigned FRAME_LEN  = 63;
    localparam int unsigned POS_W      = 6;
    localparam int unsigned IDX_W      = 5;
    localparam int unsigned VALUE_W    = 33;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned NUM_FIELDS = 22;

    localparam logic [POS_W-1:0] CHECK1_POS = POS_W'(57);
    localparam logic [POS_W-1:0] CHECK2_POS = POS_W'(62);
    localparam logic [IDX_W-1:0] LAST_FIELD = IDX_W'(NUM_FIELDS - 1);

    // Sync header bytes.
    localparam logic [7:0] SYNC0 = 8'hBD;
    localparam logic [7:0] SYNC1 = 8'hDB;
    localparam logic [7:0] SYNC2 = 8'h0B;

    // Stored type of a frame field.
    typedef enum logic [1:0] {
        KIND_S16 = 2'd0,
        KIND_S32 = 2'd1,
        KIND_U8  = 2'd2,
        KIND_U32 = 2'd3
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                wr_en;      // store the input byte at addr
        logic                rd_en;      // read the frame store at addr
        logic [POS_W-1:0]    addr;
        logic                chk_load;   // start the running XOR with the byte
        logic                chk_xor;    // fold the byte into the running XOR
        logic                chk1_cap;   // capture the first check result
        logic                acc_en;     // place read data into a word lane
        logic [1:0]          acc_lane;
        logic                out_load;   // load the output register
        logic                out_bad;    // load a bad-frame status result
        logic [STATUS_W-1:0] out_status;
        logic [IDX_W-1:0]    out_index;
        t_kind               out_kind;
        logic                out_last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_sync0;
        logic is_sync1;
        logic is_sync2;
        logic chk_match;   // input byte equals the running XOR
        logic first_ok;    // result of the first check
        logic out_free;    // output register can take a result this cycle
    } t_dp_stat;

    // Byte offset of each field in the frame.
    function automatic logic [POS_W-1:0] field_offset(input logic [IDX_W-1:0] k);
        logic [POS_W-1:0] off;
        unique case (k)
            5'd0:    off = 6'd3;
            5'd1:    off = 6'd5;
            5'd2:    off = 6'd7;
            5'd3:    off = 6'd9;
            5'd4:    off = 6'd11;
            5'd5:    off = 6'd13;
            5'd6:    off = 6'd15;
            5'd7:    off = 6'd17;
            5'd8:    off = 6'd19;
            5'd9:    off = 6'd21;
            5'd10:   off = 6'd25;
            5'd11:   off = 6'd29;
            5'd12:   off = 6'd33;
            5'd13:   off = 6'd35;
            5'd14:   off = 6'd37;
            5'd15:   off = 6'd39;
            5'd16:   off = 6'd46;
            5'd17:   off = 6'd48;
            5'd18:   off = 6'd50;
            5'd19:   off = 6'd52;
            5'd20:   off = 6'd56;
            5'd21:   off = 6'd58;
            default: off = 6'd0;
        endcase
        return off;
    endfunction

    // Stored type of each field.
    function automatic t_kind field_kind(input logic [IDX_W-1:0] k);
        t_kind kd;
        unique case (k)
            5'd9, 5'd10, 5'd11: kd = KIND_S32;
            5'd15, 5'd20:       kd = KIND_U8;
            5'd19, 5'd21:       kd = KIND_U32;
            default:            kd = KIND_S16;
        endcase
        return kd;
    endfunction

    // Index of the last byte of a field of the given type.
    function automatic logic [1:0] kind_last_byte(input t_kind kd);
        logic [1:0] lb;
        unique case (kd)
            KIND_S16: lb = 2'd1;
            KIND_S32: lb = 2'd3;
            KIND_U8:  lb = 2'd0;
            KIND_U32: lb = 2'd3;
        endcase
        return lb;
    endfunction

endpackage

FILE: rtl/core/ins_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// ins_frame_deframer_core
// Sync-header frame parser with two XOR checks for INS serial frames.
// ----------------------------------------------------------------------------
// The block takes one received serial byte per transfer, hunts for the
// header BD DB 0B and collects a 63-byte frame into a local frame store.
// Header and payload bytes are taken one per cycle while the block is not
// emitting results. When the last byte arrives, a frame that fails a check
// gives one status result; a good frame gives 22 raw fields with tlast on
// the final one. Fields are read back from the single-port frame store one
// byte at a time (read, then place), and each result is then loaded into
// the output register. s_axis_tready stays low until the last result of a
// frame is loaded, which takes longer when the output stalls.
module ins_frame_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [32:0] field_value, [39:33] zero
    output logic [6:0]  m_axis_tuser,   // [4:0] field_index, [6:5] status
    output logic        m_axis_tlast
);
    import ifd_pkg::*;

    t_dp_cmd             cmd;
    t_dp_stat            stat;
    logic [IDX_W-1:0]    field_index;
    logic [VALUE_W-1:0]  field_value;
    logic [STATUS_W-1:0] status;

    // Header hunt and emission sequencer.
    ifd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Frame store, checks and output register.
    ifd_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte        (s_axis_tdata),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_field_index (field_index),
        .o_field_value (field_value),
        .o_status      (status),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, field_value};
    assign m_axis_tuser = {status, field_index};

endmodule

FILE: rtl/core/ifd_datapath.sv
// ----------------------------------------------------------------------------
// ifd_datapath
// Frame store, running XOR check, field assembly and output register.
// ----------------------------------------------------------------------------
module ifd_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [7:0]                i_byte,
    input  ifd_pkg::t_dp_cmd          i_cmd,
    output ifd_pkg::t_dp_stat         o_stat,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [ifd_pkg::IDX_W-1:0]    o_field_index,
    output logic [ifd_pkg::VALUE_W-1:0]  o_field_value,
    output logic [ifd_pkg::STATUS_W-1:0] o_status,
    output logic                      o_last
);
    import ifd_pkg::*;

    logic [7:0]          r_mem [FRAME_LEN];
    logic [7:0]          r_rd_data;
    logic [7:0]          r_check;
    logic                r_first_ok;
    logic [31:0]         r_word;
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_index;
    logic [VALUE_W-1:0]  r_value;
    logic [STATUS_W-1:0] r_status;
    logic                r_last;
    logic [VALUE_W-1:0]  n_value;

    // Frame store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.addr] <= i_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.addr];
        end
    end

    // Running XOR of the frame bytes and the first check result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check    <= '0;
            r_first_ok <= 1'b0;
        end else begin
            if (i_cmd.chk_load) begin
                r_check <= i_byte;
            end else if (i_cmd.chk_xor) begin
                r_check <= r_check ^ i_byte;
            end
            if (i_cmd.chk1_cap) begin
                r_first_ok <= (r_check == i_byte);
            end
        end
    end

    // Little-endian field word, built one byte lane at a time.
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_en) begin
            unique case (i_cmd.acc_lane)
                2'd0: r_word[7:0]   <= r_rd_data;
                2'd1: r_word[15:8]  <= r_rd_data;
                2'd2: r_word[23:16] <= r_rd_data;
                2'd3: r_word[31:24] <= r_rd_data;
            endcase
        end
    end

    // Extend the raw word according to the field type.
    always_comb begin
        unique case (i_cmd.out_kind)
            KIND_S16: n_value = VALUE_W'($signed(r_word[15:0]));
            KIND_S32: n_value = VALUE_W'($signed(r_word));
            KIND_U8:  n_value = VALUE_W'(r_word[7:0]);
            KIND_U32: n_value = VALUE_W'(r_word);
        endcase
    end

    // Output register; a result waits here until the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_last <= i_cmd.out_last;
            if (i_cmd.out_bad) begin
                r_index  <= '0;
                r_value  <= '0;
                r_status <= i_cmd.out_status;
            end else begin
                r_index  <= i_cmd.out_index;
                r_value  <= n_value;
                r_status <= '0;
            end
        end
    end

    assign o_stat.is_sync0  = (i_byte == SYNC0);
    assign o_stat.is_sync1  = (i_byte == SYNC1);
    assign o_stat.is_sync2  = (i_byte == SYNC2);
    assign o_stat.chk_match = (r_check == i_byte);
    assign o_stat.first_ok  = r_first_ok;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_field_index = r_index;
    assign o_field_value = r_value;
    assign o_status      = r_status;
    assign o_last        = r_last;

endmodule

FILE: rtl/core/ifd_ctrl.sv
// ----------------------------------------------------------------------------
// ifd_ctrl
// Header hunt, frame position tracking and field emission sequencer.
// ----------------------------------------------------------------------------
module ifd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ifd_pkg::t_dp_stat i_stat,
    output ifd_pkg::t_dp_cmd  o_cmd
);
    import ifd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BAD,
        S_RD,
        S_ACC,
        S_OUT
    } t_state;

    t_state              r_state, n_state;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [IDX_W-1:0]    r_field, n_field;
    logic [1:0]          r_byte, n_byte;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                accept;
    logic [STATUS_W-1:0] frame_status;
    t_kind               kind;

    assign o_in_ready   = (r_state == S_IDLE);
    assign accept       = i_in_valid && o_in_ready;
    assign kind         = field_kind(r_field);
    // Bit 0 flags the first check, bit 1 the second.
    assign frame_status = {!i_stat.chk_match, !i_stat.first_ok};

    // Next state and datapath commands.
    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_field  = r_field;
        n_byte   = r_byte;
        n_status = r_status;
        o_cmd            = '0;
        o_cmd.out_kind   = kind;
        o_cmd.out_index  = r_field;
        o_cmd.out_status = r_status;
        o_cmd.acc_lane   = r_byte;
        o_cmd.addr       = r_pos;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (r_pos == '0) begin
                        if (i_stat.is_sync0) begin
                            o_cmd.wr_en    = 1'b1;
                            o_cmd.chk_load = 1'b1;
                            n_pos          = POS_W'(1);
                        end
                    end else if (r_pos == POS_W'(1) || r_pos == POS_W'(2)) begin
                        if ((r_pos == POS_W'(1) && i_stat.is_sync1) ||
                            (r_pos == POS_W'(2) && i_stat.is_sync2)) begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.chk_xor = 1'b1;
                            n_pos         = r_pos + POS_W'(1);
                        end else begin
                            n_pos = '0;
                        end
                    end else if (r_pos > CHECK2_POS) begin
                        n_pos = '0;
                    end else if (r_pos == CHECK2_POS) begin
                        // Frame complete: report a failure or emit fields.
                        o_cmd.wr_en = 1'b1;
                        n_pos       = '0;
                        n_field     = '0;
                        n_byte      = '0;
                        n_status    = frame_status;
                        if (frame_status != '0) begin
                            n_state = S_BAD;
                        end else begin
                            n_state = S_RD;
                        end
                    end else begin
                        o_cmd.wr_en    = 1'b1;
                        o_cmd.chk_xor  = 1'b1;
                        o_cmd.chk1_cap = (r_pos == CHECK1_POS);
                        n_pos          = r_pos + POS_W'(1);
                    end
                end
            end
            S_BAD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_bad  = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.addr  = field_offset(r_field) + POS_W'(r_byte);
                n_state     = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_en = 1'b1;
                if (r_byte == kind_last_byte(kind)) begin
                    n_state = S_OUT;
                end else begin
                    n_byte  = r_byte + 2'd1;
                    n_state = S_RD;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = (r_field == LAST_FIELD);
                    n_byte         = '0;
                    if (r_field == LAST_FIELD) begin
                        n_state = S_IDLE;
                    end else begin
                        n_field = r_field + IDX_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and sequencing registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_field  <= '0;
            r_byte   <= '0;
            r_status <= '0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_field  <= n_field;
            r_byte   <= n_byte;
            r_status <= n_status;
        end
    end

endmodule

FILE: sim/ins_frame_deframer_checker.sv
// ----------------------------------------------------------------------------
// ins_frame_deframer_checker
// Watches both streams of the deframer, predicts every field and compares.
// ----------------------------------------------------------------------------
// Each byte accepted on the input stream is run through a local copy of the
// header hunt, the frame store and the two XOR checks. A completed frame
// queues either one status result or its 22 decoded fields. Each transfer on
// the output stream is compared with the oldest queued field.
module ins_frame_deframer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    input  logic [7:0]  i_in_tdata,    // [7:0] data_byte
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    input  logic [39:0] i_out_tdata,   // [32:0] field_value, [39:33] zero
    input  logic [6:0]  i_out_tuser,   // [4:0] field_index, [6:5] status
    input  logic        i_out_tlast,
    output int          o_fail_count,
    output int          o_fields_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import ifd_pkg::*;

    // One result of the deframer.
    typedef struct packed {
        logic [IDX_W-1:0]    index;
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_field_rec;

    logic [7:0]       frame_bytes [FRAME_LEN];
    logic [POS_W-1:0] next_pos;
    logic [7:0]       xor_sum;
    logic             sum57_ok;
    t_field_rec       fields_due [$];
    int               fail_count;

    assign o_fail_count = fail_count;

    // Stored type of a field, by its place in the frame.
    function automatic t_kind kind_of(input int k);
        if (k >= 9 && k <= 11) return KIND_S32;
        if (k == 15 || k == 20) return KIND_U8;
        if (k == 19 || k == 21) return KIND_U32;
        return KIND_S16;
    endfunction

    // Advances the frame tracker by one byte and queues what it yields.
    task automatic take_serial_byte(input logic [7:0] b);
        t_field_rec    rec;
        logic [31:0]   word;
        int            off;
        logic          sum62_ok;
        logic [1:0]    st;
        if (next_pos == 0) begin
            if (b == SYNC0) begin
                frame_bytes[0] = b;
                xor_sum = b;
                next_pos = POS_W'(1);
            end
        end else if (next_pos == 1 || next_pos == 2) begin
            // A wrong header byte is dropped and the hunt starts over.
            if (b == ((next_pos == 1) ? SYNC1 : SYNC2)) begin
                frame_bytes[next_pos] = b;
                xor_sum ^= b;
                next_pos = next_pos + POS_W'(1);
            end else begin
                next_pos = '0;
            end
        end else if (next_pos != CHECK2_POS) begin
            frame_bytes[next_pos] = b;
            if (next_pos == CHECK1_POS) sum57_ok = (xor_sum == b);
            xor_sum ^= b;
            next_pos = next_pos + POS_W'(1);
        end else begin
            frame_bytes[next_pos] = b;
            sum62_ok = (xor_sum == b);
            st = {~sum62_ok, ~sum57_ok};
            next_pos = '0;
            xor_sum = 8'h00;
            if (st != 2'd0) begin
                rec.index  = '0;
                rec.value  = '0;
                rec.status = st;
                rec.last   = 1'b1;
                fields_due.push_back(rec);
            end else begin
                // Fields are packed back to back except before the polled
                // words and before the week.
                off = 3;
                for (int k = 0; k < NUM_FIELDS; k++) begin
                    if (k == 16) off = 46;
                    if (k == 21) off = 58;
                    word = {frame_bytes[off+3], frame_bytes[off+2],
                            frame_bytes[off+1], frame_bytes[off]};
                    rec.index  = IDX_W'(k);
                    rec.status = '0;
                    rec.last   = (k == NUM_FIELDS - 1);
                    case (kind_of(k))
                        KIND_S16: begin
                            rec.value = {{17{word[15]}}, word[15:0]};
                            off += 2;
                        end
                        KIND_S32: begin
                            rec.value = {word[31], word};
                            off += 4;
                        end
                        KIND_U8: begin
                            rec.value = {25'd0, word[7:0]};
                            off += 1;
                        end
                        default: begin
                            rec.value = {1'b0, word};
                            off += 4;
                        end
                    endcase
                    fields_due.push_back(rec);
                end
            end
        end
    endtask

    task automatic report(input string what, input logic [39:0] want,
                          input logic [39:0] got);
        $display("%0t: mismatch in %s: expected %h, actual %h", $time, what, want, got);
        fail_count++;
    endtask

    // Compare output transfers first, then feed the accepted input byte.
    always @(posedge i_clk) begin : watch
        t_field_rec want;
        if (!i_rst_n) begin
            next_pos = '0;
            xor_sum = 8'h00;
            sum57_ok = 1'b0;
            fields_due.delete();
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                if (fields_due.size() == 0) begin
                    $display("%0t: unexpected result: index %0d value %h status %0d last %0b",
                             $time, i_out_tuser[4:0], i_out_tdata[32:0],
                             i_out_tuser[6:5], i_out_tlast);
                    fail_count++;
                end else begin
                    want = fields_due.pop_front();
                    if (i_out_tuser[4:0] !== want.index)
                        report("field_index", 40'(want.index), 40'(i_out_tuser[4:0]));
                    if (i_out_tdata !== {7'd0, want.value})
                        report("field_value", {7'd0, want.value}, i_out_tdata);
                    if (i_out_tuser[6:5] !== want.status)
                        report("status", 40'(want.status), 40'(i_out_tuser[6:5]));
                    if (i_out_tlast !== want.last)
                        report("last", 40'(want.last), 40'(i_out_tlast));
                end
            end
            if (i_in_tvalid && i_in_tready) take_serial_byte(i_in_tdata);
        end
        o_fields_due <= fields_due.size();
    end

    initial fail_count = 0;

endmodule

FILE: sim/ins_frame_deframer_core_tb.sv
// ----------------------------------------------------------------------------
// ins_frame_deframer_core_tb
// Stimulus and verdict for the INS frame deframer.
// ----------------------------------------------------------------------------
// Sends header noise and broken headers, then good frames with constant and
// random payloads and frames that fail either XOR check. The source and the
// sink pause at random in several phases, and once the sink holds off long
// enough for the block to back up its input. The checker beside the block
// predicts and compares every result.
module ins_frame_deframer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ifd_pkg::*;

    localparam int RESET_CYCLES   = 9;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NUM_PHASES     = 4;
    localparam int SEND_GAP_PCT [NUM_PHASES] = '{0, 57, 0, 18};
    localparam int SINK_STALL_PCT [NUM_PHASES] = '{0, 0, 57, 18};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [6:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int fields_due;
    int send_gap_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    always #1 clk = ~clk;

    ins_frame_deframer_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    ins_frame_deframer_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_tvalid  (s_tvalid),
        .i_in_tready  (s_tready),
        .i_in_tdata   (s_tdata),
        .i_out_tvalid (m_tvalid),
        .i_out_tready (m_tready),
        .i_out_tdata  (m_tdata),
        .i_out_tuser  (m_tuser),
        .i_out_tlast  (m_tlast),
        .o_fail_count (fail_count),
        .o_fields_due (fields_due)
    );

    // Sink: random stalls, or a long hold-off when one is requested.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_tready <= 1'b0;
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sets how often the source and the sink pause in one phase.
    task automatic set_phase(input int ph);
        send_gap_pct = SEND_GAP_PCT[ph];
        stall_pct <= SINK_STALL_PCT[ph];
    endtask

    // Offers one byte, with a random gap first, and waits for its transfer.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge clk); while (!s_tready);
    endtask

    // Bytes other than the first sync byte, sent while hunting.
    task automatic send_noise(input int count);
        logic [7:0] b;
        repeat (count) begin
            do b = 8'($urandom_range(255)); while (b == SYNC0);
            send_byte(b);
        end
    endtask

    // A header cut short at its second or third byte by a wrong byte.
    task automatic send_broken_header();
        logic [7:0] b;
        logic       at_third;
        at_third = 1'($urandom_range(1));
        send_byte(SYNC0);
        if (at_third) send_byte(SYNC1);
        do b = 8'($urandom_range(255)); while (b == (at_third ? SYNC2 : SYNC1));
        send_byte(b);
    endtask

    // A whole frame; bad_mask bit 0 spoils the first check, bit 1 the second.
    // A negative fill gives a random payload.
    task automatic send_frame(input logic [1:0] bad_mask, input int fill);
        logic [7:0] fr [FRAME_LEN];
        logic [7:0] sum;
        fr[0] = SYNC0;
        fr[1] = SYNC1;
        fr[2] = SYNC2;
        for (int i = 3; i < FRAME_LEN - 1; i++)
            fr[i] = (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
        sum = 8'h00;
        for (int i = 0; i < CHECK1_POS; i++) sum ^= fr[i];
        fr[CHECK1_POS] = sum ^ (bad_mask[0] ? 8'($urandom_range(1, 255)) : 8'h00);
        sum = 8'h00;
        for (int i = 0; i < CHECK2_POS; i++) sum ^= fr[i];
        fr[CHECK2_POS] = sum ^ (bad_mask[1] ? 8'($urandom_range(1, 255)) : 8'h00);
        for (int i = 0; i < FRAME_LEN; i++) send_byte(fr[i]);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No pauses: noise, every way a header can break, then a frame
        // whose results back up while the sink holds off and the source
        // keeps offering bytes.
        set_phase(0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC1);
        send_byte(SYNC2);
        send_byte(SYNC0);
        send_byte(8'h00);
        send_byte(SYNC0);
        send_byte(SYNC0);
        send_byte(SYNC0);
        send_byte(SYNC1);
        send_byte(8'h00);
        send_byte(SYNC0);
        send_byte(SYNC1);
        send_byte(SYNC0);
        send_byte(SYNC0);
        send_byte(SYNC1);
        send_byte(8'hFF);
        hold_requests <= hold_requests + 1;
        send_frame(2'd0, 8'hFF);
        send_broken_header();

        // Source pausing, with a frame that fails the first check.
        set_phase(1);
        send_broken_header();
        send_frame(2'd1, -1);

        // Sink stalling, with a good random frame.
        set_phase(2);
        send_noise(2);
        send_frame(2'd0, -1);

        // Both pausing, with a frame that fails the second check.
        set_phase(3);
        send_noise(1);
        send_frame(2'd2, -1);
        s_tvalid <= 1'b0;
        @(posedge clk);

        // Drain, then let the block sit idle for a while.
        while (fields_due != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/ifd_pkg.sv
rtl/core/ifd_datapath.sv
rtl/core/ifd_ctrl.sv
rtl/core/ins_frame_deframer_core.sv
sim/ins_frame_deframer_checker.sv
sim/ins_frame_deframer_core_tb.sv
